/* src/assert_macros.svh */
// Assertion helpers used by the recipe table sequencer (drt_seq).
// Each macro checks on the rising edge of clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant that must hold on every clock edge outside reset.
`define DRT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define DRT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/drt_pkg.sv */
// Package for the recipe table: field widths, command and status codes,
// staging flags and the result word type. No dependencies.
package drt_pkg;

  localparam int KIND_W   = 3;
  localparam int ARG_W    = 16;
  localparam int STATUS_W = 3;
  localparam int PUMP_W   = 5;
  localparam int TIME_W   = 16;
  localparam int COUNT_W  = 4;

  localparam int DRT_MAX_ENTRIES = 8;
  localparam int PUMP_ID_MAX     = 20;

  // Command kinds
  localparam logic [KIND_W-1:0] KIND_RESET = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUMP  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TIME  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DELAY = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STORE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_GO    = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_PUMP  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO_TIME = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISSING   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

  // Staging flags
  localparam logic [1:0] FLAG_PUMP = 2'b01;
  localparam logic [1:0] FLAG_TIME = 2'b10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                has_entry;
    logic [PUMP_W-1:0]   pump_id;
    logic [TIME_W-1:0]   run_time;
    logic [TIME_W-1:0]   start_delay;
    logic [COUNT_W-1:0]  entry_count;
    logic                last;
  } result_t;

endpackage

/* src/drt_cmd_if.sv */
// Command channel: valid/ready handshake carrying kind and argument.
// Depends on drt_pkg.
interface drt_cmd_if import drt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ARG_W-1:0]  argument;

  modport source(output valid, kind, argument, input ready);
  modport sink(input valid, kind, argument, output ready);
endinterface

/* src/drt_res_if.sv */
// Result channel: valid/ready handshake carrying status and one table entry.
// Depends on drt_pkg.
interface drt_res_if import drt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                has_entry;
  logic [PUMP_W-1:0]   pump_id;
  logic [TIME_W-1:0]   run_time;
  logic [TIME_W-1:0]   start_delay;
  logic [COUNT_W-1:0]  entry_count;
  logic                last;

  modport source(output valid, status, has_entry, pump_id, run_time, start_delay,
                 entry_count, last, input ready);
  modport sink(input valid, status, has_entry, pump_id, run_time, start_delay,
               entry_count, last, output ready);
endinterface

/* src/dispense_recipe_table_unit.sv */
// Recipe table top level: sequencer with entry RAM plus the result register.
// Depends on drt_pkg, drt_cmd_if, drt_res_if, drt_seq.
//
// Use: commands enter on cmd (kind, argument) with a valid/ready handshake;
// result words leave on res. Stage pump, stage duration, stage delay, reset
// and a failed store or an empty go each give one word. A store gives one
// word after comparing the staged pump against the stored entries, one
// entry per cycle through the table RAM read port. Go gives one word per
// stored entry, in table order, last set on the final one, then clears all.
// Unknown kinds give no word.
// A simple command's word is loaded from the decode state into the output
// register; a store's after the scan of up to MAX_ENTRIES - 1 entries and
// the write state; go's words from the emit state, one per cycle while the
// output register is free. A new command is taken once the previous one is
// finished; the table RAM has a single read port that walks the entries.
// Reset (rst, synchronous) empties the table and the staged values at once.
// A stalled receiver holds the result word; the sequencer waits on it, and
// one command may be taken while a finished word still waits.
module dispense_recipe_table_unit import drt_pkg::*; #(
  parameter int MAX_ENTRIES = DRT_MAX_ENTRIES
) (
  input logic       clk,
  input logic       rst,
  drt_cmd_if.sink   cmd,
  drt_res_if.source res
);

  logic    res_load;
  result_t res_word;
  result_t res_q;
  logic    res_valid;
  logic    out_free;

  assign out_free = !res_valid || res.ready;

  drt_seq #(.MAX_ENTRIES(MAX_ENTRIES)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .out_free (out_free),
    .res_load (res_load),
    .res_word (res_word)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res_word;
    end
  end

  assign res.valid       = res_valid;
  assign res.status      = res_q.status;
  assign res.has_entry   = res_q.has_entry;
  assign res.pump_id     = res_q.pump_id;
  assign res.run_time    = res_q.run_time;
  assign res.start_delay = res_q.start_delay;
  assign res.entry_count = res_q.entry_count;
  assign res.last        = res_q.last;

endmodule

/* src/drt_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module drt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/drt_seq.sv */
// Command sequencer: decodes commands, holds staged values and the entry count,
// scans and updates the entry RAM. Depends on drt_pkg, drt_cmd_if, drt_ram.
`include "assert_macros.svh"

module drt_seq import drt_pkg::*; #(
  parameter int MAX_ENTRIES = DRT_MAX_ENTRIES
) (
  input  logic      clk,
  input  logic      rst,
  drt_cmd_if.sink   cmd,
  input  logic      out_free,
  output logic      res_load,
  output result_t   res_word
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int EW = PUMP_W + 2 * TIME_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_WRITE  = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0]        state, state_next;
  logic [KIND_W-1:0] kind_q, kind_next;
  logic [ARG_W-1:0]  arg_q, arg_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     idx, idx_next;
  logic [CW-1:0]     slot, slot_next;
  logic [PUMP_W-1:0] staged_pump, staged_pump_next;
  logic [TIME_W-1:0] staged_time, staged_time_next;
  logic [TIME_W-1:0] staged_delay, staged_delay_next;
  logic [1:0]        staged_flags, staged_flags_next;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [EW-1:0]     ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [EW-1:0]     ram_rdata;

  logic              full;
  logic              ready_to_store;
  logic [CW-1:0]     idx_inc;
  logic [PUMP_W-1:0] rd_pump;
  logic [TIME_W-1:0] rd_time;
  logic [TIME_W-1:0] rd_delay;

  assign cmd.ready      = (state == S_IDLE);
  assign full           = (count == CW'(MAX_ENTRIES));
  assign ready_to_store = ((staged_flags & FLAG_PUMP) != '0) &&
                          ((staged_flags & FLAG_TIME) != '0);
  assign idx_inc        = idx + CW'(1);
  assign rd_pump        = ram_rdata[EW-1 -: PUMP_W];
  assign rd_time        = ram_rdata[2*TIME_W-1 -: TIME_W];
  assign rd_delay       = ram_rdata[TIME_W-1:0];

  // Entry table: pump, run time and delay packed into one word
  drt_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer next-state logic
  always_comb begin
    logic [STATUS_W-1:0] status_v;
    logic [CW-1:0]       cnt_v;

    status_v          = ST_OK;
    cnt_v             = count;
    state_next        = state;
    kind_next         = kind_q;
    arg_next          = arg_q;
    count_next        = count;
    idx_next          = idx;
    slot_next         = slot;
    staged_pump_next  = staged_pump;
    staged_time_next  = staged_time;
    staged_delay_next = staged_delay;
    staged_flags_next = staged_flags;
    res_load          = 1'b0;
    res_word          = '0;
    ram_we            = 1'b0;
    ram_waddr         = slot[AW-1:0];
    ram_wdata         = {staged_pump, staged_time, staged_delay};
    ram_raddr         = idx[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          kind_next  = cmd.kind;
          arg_next   = cmd.argument;
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        priority if (kind_q == KIND_STORE && !full && ready_to_store) begin
          idx_next  = '0;
          ram_raddr = '0;
          if (count == '0) begin
            slot_next  = count;
            state_next = S_WRITE;
          end else begin
            state_next = S_SCAN;
          end
        end else if (kind_q == KIND_GO && count != '0) begin
          idx_next   = '0;
          ram_raddr  = '0;
          state_next = S_EMIT;
        end else if (kind_q > KIND_GO) begin
          // unknown kind: dropped silently
          state_next = S_IDLE;
        end else if (out_free) begin
          unique case (kind_q)
            KIND_RESET: begin
              count_next        = '0;
              staged_pump_next  = '0;
              staged_time_next  = '0;
              staged_delay_next = '0;
              staged_flags_next = '0;
              cnt_v             = '0;
            end
            KIND_PUMP: begin
              if (arg_q == '0 || arg_q > ARG_W'(PUMP_ID_MAX)) begin
                status_v = ST_BAD_PUMP;
              end else if (full) begin
                status_v = ST_FULL;
              end else begin
                staged_pump_next  = arg_q[PUMP_W-1:0];
                staged_flags_next = staged_flags | FLAG_PUMP;
              end
            end
            KIND_TIME: begin
              if (arg_q == '0) begin
                status_v = ST_ZERO_TIME;
              end else if (full) begin
                status_v = ST_FULL;
              end else begin
                staged_time_next  = arg_q;
                staged_flags_next = staged_flags | FLAG_TIME;
              end
            end
            KIND_DELAY: begin
              staged_delay_next = arg_q;
            end
            KIND_STORE: begin
              status_v = full ? ST_FULL : ST_MISSING;
            end
            default: begin
              // go with an empty table
              status_v = ST_EMPTY;
            end
          endcase
          res_load             = 1'b1;
          res_word.status      = status_v;
          res_word.entry_count = COUNT_W'(cnt_v);
          res_word.last        = 1'b1;
          state_next           = S_IDLE;
        end else begin
          // output register still holds a word; wait for it to drain
          state_next = S_DECODE;
        end
      end

      // One entry compared per cycle; data for idx is on the read port
      S_SCAN: begin
        if (rd_pump == staged_pump) begin
          slot_next  = idx;
          state_next = S_WRITE;
        end else if (idx_inc == count) begin
          slot_next  = count;
          state_next = S_WRITE;
        end else begin
          idx_next  = idx_inc;
          ram_raddr = idx_inc[AW-1:0];
        end
      end

      S_WRITE: begin
        if (out_free) begin
          ram_we = 1'b1;
          if (slot == count) begin
            count_next = count + CW'(1);
          end
          res_load             = 1'b1;
          res_word.status      = ST_OK;
          res_word.entry_count = COUNT_W'((slot == count) ? count + CW'(1) : count);
          res_word.last        = 1'b1;
          state_next           = S_IDLE;
        end
      end

      // One entry per result word; a stall re-reads the same address
      S_EMIT: begin
        if (out_free) begin
          res_load             = 1'b1;
          res_word.status      = ST_OK;
          res_word.has_entry   = 1'b1;
          res_word.pump_id     = rd_pump;
          res_word.run_time    = rd_time;
          res_word.start_delay = rd_delay;
          res_word.entry_count = '0;
          res_word.last        = (idx_inc == count);
          if (idx_inc == count) begin
            count_next        = '0;
            staged_pump_next  = '0;
            staged_time_next  = '0;
            staged_delay_next = '0;
            staged_flags_next = '0;
            state_next        = S_IDLE;
          end else begin
            idx_next  = idx_inc;
            ram_raddr = idx_inc[AW-1:0];
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      staged_pump  <= '0;
      staged_time  <= '0;
      staged_delay <= '0;
      staged_flags <= '0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      staged_pump  <= staged_pump_next;
      staged_time  <= staged_time_next;
      staged_delay <= staged_delay_next;
      staged_flags <= staged_flags_next;
    end
  end

  // Command and walk registers
  always_ff @(posedge clk) begin
    kind_q <= kind_next;
    arg_q  <= arg_next;
    idx    <= idx_next;
    slot   <= slot_next;
  end

  `DRT_ASSERT_ALWAYS(a_count_bound, count <= CW'(MAX_ENTRIES), "entry count above table size")
  `DRT_ASSERT_IMPL(a_load_free, res_load, out_free, "result loaded into a busy output register")
  `DRT_ASSERT_IMPL(a_write_slot, ram_we, slot <= count && !full, "table write outside the fill range")
  `DRT_ASSERT_NEXT(a_go_clears, res_load && res_word.has_entry && res_word.last,
                   count == '0 && staged_flags == '0, "go did not clear the table")

endmodule
